// ----- sv/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and the microcode table of the matrix multiply
// engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int DIM_W     = 4;   // configuration register width
  localparam int IDX_W     = 3;   // row / column index width
  localparam int POS_W     = 8;   // load position width
  localparam int ELEM_W    = 16;  // Q8.8 element
  localparam int PROD_W    = 32;  // Q16.16 product
  localparam int SUM_W     = 35;  // Q19.16 exact sum
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = CFG_IDX_W'(2);

  // Microcode addresses
  typedef logic [3:0] step_t;
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_ROW_CLR  = 4'd1;
  localparam step_t S_COL_CLR  = 4'd2;
  localparam step_t S_DOT_CLR  = 4'd3;
  localparam step_t S_MAC      = 4'd4;
  localparam step_t S_DRAIN0   = 4'd5;
  localparam step_t S_DRAIN1   = 4'd6;
  localparam step_t S_EMIT     = 4'd7;
  localparam step_t S_ROW_NEXT = 4'd8;
  localparam step_t S_DONE     = 4'd9;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEXT,      // never jump
    C_ALWAYS,
    C_NOT_DONE,  // load not finished in this cycle
    C_J_MORE,    // more inner products in this dot product
    C_K_MORE,    // more columns in this row
    C_I_MORE     // more rows
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  row_clr;   // i = 0, A row base = 0
    logic  col_clr;   // k = 0
    logic  dot_clr;   // j = 0, load read addresses, clear sum
    logic  rd;        // issue one read pair, advance j
    logic  emit;      // present sum, advance k
    logic  row_next;  // advance i and A row base
  } ucw_t;

  typedef struct packed {
    logic load_done;
    logic j_more;
    logic k_more;
    logic i_more;
  } stat_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } dims_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxd);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxd) r = maxd;
    return r;
  endfunction

  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w = '{cond: C_NEXT, target: S_IDLE, default: 1'b0};
    case (s)
      S_IDLE: begin
        w.cond   = C_NOT_DONE;
        w.target = S_IDLE;
      end
      S_ROW_CLR:  w.row_clr = 1'b1;
      S_COL_CLR:  w.col_clr = 1'b1;
      S_DOT_CLR:  w.dot_clr = 1'b1;
      S_MAC: begin
        w.rd     = 1'b1;
        w.cond   = C_J_MORE;
        w.target = S_MAC;
      end
      S_DRAIN0:   w.cond = C_NEXT;
      S_DRAIN1:   w.cond = C_NEXT;
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_K_MORE;
        w.target = S_DOT_CLR;
      end
      S_ROW_NEXT: begin
        w.row_next = 1'b1;
        w.cond     = C_I_MORE;
        w.target   = S_COL_CLR;
      end
      S_DONE: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/matrix_multiply_engine.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// C = A x B on signed Q8.8 elements, exact Q19.16 results, one shared MAC
// under a microcoded sequencer.
//
// Usage: write row_count, inner_count and col_count (index 0, 1, 2) through
// cfg_we / cfg_index / cfg_data while the block is idle; 0 acts as 1 and
// values above MAX_DIM act as MAX_DIM. Feed A row-major, then B row-major,
// one element per transaction on start / in_element_value; a transaction
// is taken when start is high and busy is low, one per cycle while loading.
// The transaction that delivers the last B element raises busy and starts
// the compute program. Results come out row-major, one per out_valid pulse,
// with row, column and a last marker on the final element.
// Compute time after the last element is set by the single MAC and its read,
// multiply and accumulate pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, rst_n low) clears the load position, sequencer and
// output strobe and sets every dimension to 8; the stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // element input
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] in_element_value,
  // result output
  output logic                     out_valid,
  output logic signed [SUM_W-1:0]  out_product_value,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic                     out_last_element,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data
);

  logic [DIM_W-1:0] row_count_r, inner_count_r, col_count_r;
  logic [DIM_W-1:0] max_dim;
  dims_t            dims;
  ucw_t             ctrl;
  stat_t            stat;
  logic             accept;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= DIM_RESET;
      inner_count_r <= DIM_RESET;
      col_count_r   <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT:   row_count_r   <= cfg_data;
        REG_INNER_COUNT: inner_count_r <= cfg_data;
        REG_COL_COUNT:   col_count_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp dimensions into 1..MAX_DIM
  assign max_dim    = DIM_W'(MAX_DIM);
  assign dims.rows  = clamp_dim(row_count_r, max_dim);
  assign dims.inner = clamp_dim(inner_count_r, max_dim);
  assign dims.cols  = clamp_dim(col_count_r, max_dim);

  // An element transaction completes only while the sequencer idles
  assign accept = start && !busy;

  mme_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  mme_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .accept   (accept),
    .elem     (in_element_value),
    .ctrl     (ctrl),
    .stat     (stat),
    .res_valid(out_valid),
    .res_value(out_product_value),
    .res_row  (out_row),
    .res_col  (out_col),
    .res_last (out_last_element)
  );

endmodule

// ----- sv/mme_ram.sv -----
// ----------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/mme_seq.sv -----
// ----------------------------------------------------------------------------
// mme_seq
// Microcode sequencer: step counter, control word lookup, conditional jumps.
// ----------------------------------------------------------------------------
module mme_seq
  import mme_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ucw_t  ctrl,
  output logic  busy
);

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = ucode(step_r);
  assign busy = (step_r != S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOT_DONE: take = !stat.load_done;
      C_J_MORE:   take = stat.j_more;
      C_K_MORE:   take = stat.k_more;
      C_I_MORE:   take = stat.i_more;
      default:    take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_t'(step_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- sv/mme_dp.sv -----
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: load position, A and B stores, loop counters, read address
// generation, multiply-accumulate pipeline and result registers.
// ----------------------------------------------------------------------------
module mme_dp
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dims_t                    dims,
  input  logic                     accept,
  input  logic signed [ELEM_W-1:0] elem,
  input  ucw_t                     ctrl,
  output stat_t                    stat,
  output logic                     res_valid,
  output logic signed [SUM_W-1:0]  res_value,
  output logic [IDX_W-1:0]         res_row,
  output logic [IDX_W-1:0]         res_col,
  output logic                     res_last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  a_size, total;
  logic              in_a, done;

  logic [IDX_W-1:0]  i_r, j_r, k_r;
  logic [ADDR_W-1:0] a_base_r, a_addr_r, b_addr_r;

  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic              rd_vld_r, mul_vld_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_value_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic                     out_last_r;

  // Load bookkeeping
  assign a_size = POS_W'(dims.rows) * POS_W'(dims.inner);
  assign total  = a_size + (POS_W'(dims.inner) * POS_W'(dims.cols));
  assign in_a   = (pos_r < a_size);
  assign done   = accept && ((pos_r + POS_W'(1)) >= total);
  assign pos_nxt = done ? '0 : (pos_r + POS_W'(1));

  assign stat.load_done = done;
  assign stat.j_more = ({1'b0, j_r} + 4'd1) < dims.inner;
  assign stat.k_more = ({1'b0, k_r} + 4'd1) < dims.cols;
  assign stat.i_more = ({1'b0, i_r} + 4'd1) < dims.rows;

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left (
    .clk  (clk),
    .we   (accept && in_a),
    .waddr(ADDR_W'(pos_r)),
    .wdata(elem),
    .raddr(a_addr_r),
    .rdata(a_rdata)
  );

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right (
    .clk  (clk),
    .we   (accept && !in_a),
    .waddr(ADDR_W'(pos_r - a_size)),
    .wdata(elem),
    .raddr(b_addr_r),
    .rdata(b_rdata)
  );

  // Loop counters and read addresses
  always_ff @(posedge clk) begin
    if (ctrl.row_clr) begin
      i_r      <= '0;
      a_base_r <= '0;
    end else if (ctrl.row_next) begin
      i_r      <= i_r + IDX_W'(1);
      a_base_r <= a_base_r + ADDR_W'(dims.inner);
    end
    if (ctrl.col_clr) begin
      k_r <= '0;
    end else if (ctrl.emit) begin
      k_r <= k_r + IDX_W'(1);
    end
    if (ctrl.dot_clr) begin
      j_r      <= '0;
      a_addr_r <= a_base_r;
      b_addr_r <= ADDR_W'(k_r);
    end else if (ctrl.rd) begin
      j_r      <= j_r + IDX_W'(1);
      a_addr_r <= a_addr_r + ADDR_W'(1);
      b_addr_r <= b_addr_r + ADDR_W'(dims.cols);
    end
    mul_r <= $signed(a_rdata) * $signed(b_rdata);
    if (ctrl.emit) begin
      out_value_r <= sum_r;
      out_row_r   <= i_r;
      out_col_r   <= k_r;
      out_last_r  <= !stat.i_more && !stat.k_more;
    end
  end

  // Control registers and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r <= pos_nxt;
      end
      rd_vld_r    <= ctrl.rd;
      mul_vld_r   <= rd_vld_r;
      out_valid_r <= ctrl.emit;
      if (ctrl.dot_clr) begin
        sum_r <= '0;
      end else if (mul_vld_r) begin
        sum_r <= sum_r + SUM_W'(mul_r);
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res_value = out_value_r;
  assign res_row   = out_row_r;
  assign res_col   = out_col_r;
  assign res_last  = out_last_r;

endmodule

// ----- tb/mme_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_checker
// Scoreboard for the matrix multiply engine. It tracks the register file and
// the A / B element load, predicts every C element when a load completes and
// compares each out_valid pulse with the oldest predicted element.
// ----------------------------------------------------------------------------
module mme_checker
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     out_valid,
  input  logic signed [SUM_W-1:0]  out_product_value,
  input  logic [IDX_W-1:0]         out_row,
  input  logic [IDX_W-1:0]         out_col,
  input  logic                     out_last_element,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       loads_done
);

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } c_elem_t;

  logic signed [ELEM_W-1:0] a_mem [64];
  logic signed [ELEM_W-1:0] b_mem [64];
  logic [POS_W-1:0]         fill_pos;
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         inner_reg;
  logic [DIM_W-1:0]         cols_reg;
  c_elem_t                  c_expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    loads_done = 0;
  end

  function automatic int fit_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic predict_product(input int nr, input int ni, input int nc);
    longint  acc;
    c_elem_t e;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        acc = 0;
        for (int j = 0; j < ni; j++) begin
          acc += longint'(a_mem[(r * ni + j) % 64]) * longint'(b_mem[(j * nc + c) % 64]);
        end
        e.value = acc[SUM_W-1:0];
        e.row   = r[IDX_W-1:0];
        e.col   = c[IDX_W-1:0];
        e.last  = (r == nr - 1) && (c == nc - 1);
        c_expected_q.push_back(e);
      end
    end
  endtask

  task automatic take_element(input logic signed [ELEM_W-1:0] v);
    int nr;
    int ni;
    int nc;
    int a_size;
    int total;
    int pos;
    nr     = fit_dim(rows_reg);
    ni     = fit_dim(inner_reg);
    nc     = fit_dim(cols_reg);
    a_size = nr * ni;
    total  = a_size + ni * nc;
    pos    = int'(fill_pos);
    if (pos < a_size) a_mem[pos % 64] = v;
    else b_mem[(pos - a_size) % 64] = v;
    if (pos + 1 < total) begin
      fill_pos = POS_W'(pos + 1);
    end else begin
      fill_pos = '0;
      loads_done++;
      predict_product(nr, ni, nc);
    end
  endtask

  task automatic check_result();
    c_elem_t e;
    if (c_expected_q.size() == 0) begin
      $error("unexpected result: row %0d col %0d value %0d",
             out_row, out_col, out_product_value);
      fail_count++;
    end else begin
      e = c_expected_q.pop_front();
      if (out_product_value !== e.value) begin
        $error("product_value: expected %0d, got %0d", e.value, out_product_value);
        fail_count++;
      end
      if (out_row !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, out_row);
        fail_count++;
      end
      if (out_col !== e.col) begin
        $error("out_col: expected %0d, got %0d", e.col, out_col);
        fail_count++;
      end
      if (out_last_element !== e.last) begin
        $error("last_element: expected %0d, got %0d", e.last, out_last_element);
        fail_count++;
      end
    end
  endtask

  // Results leaving on this edge belong to earlier loads, so check them
  // before taking the element of this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_pos  = '0;
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      c_expected_q.delete();
    end else begin
      if (out_valid) check_result();
      if (start && !busy) take_element(in_element_value);
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_COUNT:   rows_reg = cfg_data;
          REG_INNER_COUNT: inner_reg = cfg_data;
          REG_COL_COUNT:   cols_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = c_expected_q.size();
  end

endmodule

// ----- tb/tb_matrix_multiply_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine
// Drives element transactions and register writes into the matrix multiply
// engine: a few directed loads at the value and size extremes, then random
// loads over three sender idle levels, including register changes in the
// middle of a load. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;       // sequencer tail after the last result
  localparam int END_CYCLES    = 50;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 70;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  localparam logic signed [ELEM_W-1:0] Q_MIN     = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] Q_MAX     = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] Q_ONE     = 16'sh0100;
  localparam logic signed [ELEM_W-1:0] Q_LSB     = 16'sh0001;
  localparam logic signed [ELEM_W-1:0] Q_NEG_LSB = 16'shFFFF;
  localparam logic signed [ELEM_W-1:0] Q_ZERO    = 16'sh0000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_product_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last_element;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DIM_W-1:0]         cfg_data;

  int fail_count;
  int pending;
  int loads_done;
  int idle_pct;
  int sent_count;
  int cycle_count;

  matrix_multiply_engine DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_element  (out_last_element),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  mme_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_element  (out_last_element),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .loads_done        (loads_done)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Element values lean on the Q8.8 extremes; the rest are uniform so that
  // every bit toggles.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return Q_ZERO;
      3: return Q_NEG_LSB;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small matrices; now and then full size, zero or out-of-range
  // values that the block must clamp.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(19))
      0: return '0;
      1, 2: return DIM_W'($urandom_range(9, 15));
      3, 4, 5: return DIM_W'($urandom_range(5, 8));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Offer one element, idling first at the current rate. Start stays high
  // after the transaction so that back-to-back elements need no extra step.
  task automatic send_element(input logic signed [ELEM_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start            <= 1'b0;
      in_element_value <= ELEM_W'($urandom);
      @(negedge clk);
    end
    start            <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (busy);
    sent_count++;
    @(negedge clk);
  endtask

  // Drop start and hold until every predicted result has left and the
  // sequencer has wound down; register writes may follow.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the dimension registers selected by mask (bit 0 rows, bit 1
  // inner, bit 2 cols); sometimes hit the unused index first.
  task automatic program_dims(input logic [2:0] mask, input logic [DIM_W-1:0] r,
                              input logic [DIM_W-1:0] i, input logic [DIM_W-1:0] c);
    logic [DIM_W-1:0] vals [3];
    vals[0] = r;
    vals[1] = i;
    vals[2] = c;
    start <= 1'b0;
    if ($urandom_range(3) == 0) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_UNUSED;
      cfg_data  <= DIM_W'($urandom);
      @(negedge clk);
    end
    for (int k = 0; k < 3; k++) begin
      if (mask[k]) begin
        cfg_we    <= 1'b1;
        cfg_index <= (k == 0) ? REG_ROW_COUNT : (k == 1) ? REG_INNER_COUNT : REG_COL_COUNT;
        cfg_data  <= vals[k];
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Feed random elements until the checker sees the load complete.
  task automatic load_matrix();
    int done_before;
    done_before = loads_done;
    do send_element(pick_element()); while (loads_done == done_before);
  endtask

  initial begin
    logic signed [ELEM_W-1:0] b_row [8];
    int idle_levels [3];
    int phase_start;
    int done_before;
    int partial;

    idle_levels      = '{32, 73, 0};
    b_row            = '{Q_MAX, Q_MIN, Q_ZERO, Q_NEG_LSB, Q_LSB, Q_MAX, Q_MIN, Q_ONE};
    rst_n            = 1'b0;
    start            = 1'b0;
    in_element_value = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_ROW_COUNT;
    cfg_data         = '0;
    idle_pct         = 32;
    sent_count       = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 1 x 8 x 1 with inner left at its reset value, all most
    // negative values, so the one sum reaches the top of the range.
    program_dims(3'b101, DIM_W'(1), DIM_W'(0), DIM_W'(1));
    repeat (16) send_element(Q_MIN);
    drain();

    // Directed: rows written as 0 (acts as 1) and cols as 15 (acts as 8);
    // one A element against a B row of extremes.
    program_dims(3'b111, DIM_W'(0), DIM_W'(1), DIM_W'(15));
    send_element(Q_MIN);
    foreach (b_row[n]) send_element(b_row[n]);
    drain();

    // Directed: smallest matrix, largest positive square.
    program_dims(3'b111, DIM_W'(1), DIM_W'(1), DIM_W'(1));
    send_element(Q_MAX);
    send_element(Q_MAX);
    drain();

    // Full-size load: fills every store entry, so later mid-load register
    // changes never read an entry that was never written.
    program_dims(3'b111, DIM_W'(8), DIM_W'(8), DIM_W'(8));
    load_matrix();

    foreach (idle_levels[p]) begin
      idle_pct    = idle_levels[p];
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0: begin
            // Change the dimensions part way through a load.
            drain();
            program_dims(3'b111, pick_dim(), pick_dim(), pick_dim());
            done_before = loads_done;
            partial     = $urandom_range(1, 3);
            repeat (partial) begin
              if (loads_done == done_before) send_element(pick_element());
            end
            if (loads_done == done_before) begin
              program_dims(3'b111, pick_dim(), pick_dim(), pick_dim());
              load_matrix();
            end
          end
          1: begin
            // Pause until the previous matrix has fully drained.
            drain();
            load_matrix();
          end
          2, 3, 4, 5, 6: begin
            drain();
            program_dims(3'($urandom_range(1, 7)), pick_dim(), pick_dim(), pick_dim());
            load_matrix();
          end
          default: load_matrix();
        endcase
      end
    end

    // Let the last matrix finish, then give the block a little extra time
    // to show any stray result.
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
